/* rtl/core/sorted_list_insert_defines.svh */
// Assertion macros shared by the sorted list insert RTL.
`ifndef SORTED_LIST_INSERT_DEFINES_SVH
`define SORTED_LIST_INSERT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SLI_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define SLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sli_pkg.sv */
// Types and constants for the sorted list insert block.
package sli_pkg;

  localparam int Capacity = 16;
  localparam int KeyW     = 32;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int IdxW     = $clog2(Capacity);

  typedef enum logic {
    OpInsert = 1'b0,
    OpList   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StDropped  = 2'd1,
    StListed   = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SIdle = 2'b01,
    SList = 2'b10
  } state_e;

  typedef struct packed {
    op_e                    operation;
    logic signed [KeyW-1:0] key;
  } in_req_t;

  typedef struct packed {
    status_e                status;
    logic signed [KeyW-1:0] value;
    logic                   last;
  } out_res_t;

  // broadcast command to every cell
  typedef struct packed {
    logic                   ins;
    logic                   rot;
    logic signed [KeyW-1:0] key;
  } cell_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                   valid;
    logic                   place;
    logic signed [KeyW-1:0] entry;
  } cell_link_t;

endpackage

/* rtl/core/sli_cell.sv */
// One storage cell of the sorted chain: insert-shift and list rotation.
module sli_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sli_pkg::cell_cmd_t     cmd_i,
  input  sli_pkg::cell_link_t    left_i,
  input  sli_pkg::cell_link_t    right_i,
  input  logic signed [sli_pkg::KeyW-1:0] head_i,
  output sli_pkg::cell_link_t    link_o
);

  logic                           valid_q, valid_d;
  logic signed [sli_pkg::KeyW-1:0] entry_q, entry_d;
  logic                           ge;

  // entry not less than key, or free slot: new key lands here or earlier
  assign ge = valid_q && !(entry_q < cmd_i.key);
  assign link_o.valid = valid_q;
  assign link_o.place = ge || !valid_q;
  assign link_o.entry = entry_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (left_i.place) begin
        valid_d = left_i.valid;
        entry_d = left_i.entry;
      end else if (link_o.place) begin
        valid_d = 1'b1;
        entry_d = cmd_i.key;
      end
    end else if (cmd_i.rot && valid_q) begin
      // tail wraps to the head
      entry_d = right_i.valid ? right_i.entry : head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* rtl/core/sli_out_buf.sv */
// Output register with skid slot for result requests.
module sli_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sli_pkg::out_res_t   push_res_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sli_pkg::out_res_t   out_res_o
);

  logic              out_valid_q, skid_valid_q;
  sli_pkg::out_res_t out_q, skid_q;
  logic              pop;

  assign pop         = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= skid_valid_q && push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : push_res_i;
      if (push_i) begin
        skid_q <= push_res_i;
      end
    end else if (push_i) begin
      skid_q <= push_res_i;
    end
  end

endmodule

/* rtl/core/sorted_list_insert.sv */
// Sorted list insert: top level with cell chain, sequencer and output buffer.
//
// Usage: requests arrive on in_valid_i / in_stall_o / in_req_i; a request is
// taken on a rising edge with in_valid_i high and in_stall_o low. Results
// leave on out_valid_o / out_stall_i / out_res_o under the same rule.
// For an insert request every cell compares the key with its entry at once
// and the chain shifts by one place from the insert point, so a new insert
// can be taken every cycle while in_stall_o is low. Its single result
// (inserted, or dropped when all Capacity cells hold keys) is registered in
// the output buffer. For a list request with n stored keys the accept cycle
// starts the walk, then, while the output buffer has room, the chain rotates
// one place per cycle and cell 0 supplies each key in order, the last one
// flagged. Each key goes from the SList state into the output buffer; after
// n steps the chain is back in order. An empty store gives one "empty"
// result. in_stall_o is high while a list runs.
// A two-entry output buffer (register plus skid slot) lets a request be
// taken while an earlier result still waits; when the receiver stalls long
// enough to fill both slots, in_stall_o rises and the chain holds.
// Reset (rst_ni low, asynchronous) empties the store and the output buffer;
// stored keys need no clearing because only valid cells are ever read.
`include "sorted_list_insert_defines.svh"

module sorted_list_insert (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sli_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sli_pkg::out_res_t  out_res_o
);

  sli_pkg::state_e               state_q, state_d;
  logic [sli_pkg::CntW-1:0]      count_q, count_d;
  logic [sli_pkg::IdxW-1:0]      idx_q, idx_d;
  logic [sli_pkg::CntW-1:0]      count_inc;
  logic [sli_pkg::CntW-1:0]      cells_used;

  sli_pkg::cell_cmd_t            cmd;
  sli_pkg::cell_link_t           links [sli_pkg::Capacity];
  logic [sli_pkg::Capacity-1:0]  valid_vec;
  logic                          sorted_ok;

  logic                          in_acc;
  logic                          ins_grow;
  logic                          full;
  logic                          buf_full;
  logic                          list_last;
  logic                          push;
  sli_pkg::out_res_t             push_res;

  assign in_stall_o = (state_q != sli_pkg::SIdle) || buf_full;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == sli_pkg::CntW'(sli_pkg::Capacity));
  assign list_last  = ((sli_pkg::CntW'(idx_q) + sli_pkg::CntW'(1)) == count_q);
  assign count_inc  = count_q + sli_pkg::CntW'(1);
  assign ins_grow   = in_acc && (in_req_i.operation == sli_pkg::OpInsert) && !full;

  // Sequencer: one insert per insert request unless full, or a walk of count_q rotations.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    push     = 1'b0;
    push_res = '{status: sli_pkg::StInserted, value: in_req_i.key, last: 1'b1};
    cmd      = '{ins: 1'b0, rot: 1'b0, key: in_req_i.key};
    case (state_q)
      sli_pkg::SIdle: begin
        if (in_acc) begin
          push = 1'b1;
          if (in_req_i.operation == sli_pkg::OpInsert) begin
            if (full) begin
              push_res.status = sli_pkg::StDropped;
            end else begin
              cmd.ins = 1'b1;
              count_d = count_inc;
            end
          end else if (count_q == '0) begin
            push_res = '{status: sli_pkg::StEmpty, value: '0, last: 1'b1};
          end else begin
            push    = 1'b0;
            idx_d   = '0;
            state_d = sli_pkg::SList;
          end
        end
      end
      sli_pkg::SList: begin
        if (!buf_full) begin
          push     = 1'b1;
          push_res = '{status: sli_pkg::StListed, value: links[0].entry, last: list_last};
          cmd.rot  = 1'b1;
          idx_d    = idx_q + sli_pkg::IdxW'(1);
          if (list_last) begin
            state_d = sli_pkg::SIdle;
          end
        end
      end
      default: begin
        state_d = sli_pkg::SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sli_pkg::SIdle;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Cell chain: cell 0 holds the smallest key.
  for (genvar i = 0; i < sli_pkg::Capacity; i++) begin : g_cell
    sli_pkg::cell_link_t left_link, right_link;
    if (i == 0) begin : g_head
      assign left_link = '0;
    end else begin : g_mid
      assign left_link = links[i-1];
    end
    if (i == sli_pkg::Capacity - 1) begin : g_tail
      assign right_link = '0;
    end else begin : g_inner
      assign right_link = links[i+1];
    end
    assign valid_vec[i] = links[i].valid;

    sli_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left_link),
      .right_i (right_link),
      .head_i  (links[0].entry),
      .link_o  (links[i])
    );
  end

  sli_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_res_i  (push_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  // Adjacent valid cells must be in ascending order between requests.
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 1; i < sli_pkg::Capacity; i++) begin
      if (links[i].valid && (links[i].entry < links[i-1].entry)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  assign cells_used = sli_pkg::CntW'($countones(valid_vec));

  `SLI_ASSERT_ALWAYS(a_count_matches_cells, cells_used == count_q, "count/cells mismatch")
  `SLI_ASSERT_IMP(a_idle_sorted, state_q == sli_pkg::SIdle, sorted_ok, "chain out of order")
  `SLI_ASSERT_IMP(a_list_nonempty, state_q == sli_pkg::SList, count_q != '0, "listing empty")
  `SLI_ASSERT_NXT(a_insert_grows, ins_grow, count_q == $past(count_inc), "store did not grow")

endmodule
